// ===== rtl/assert_macros.svh =====
// assertion macros for the ring run midpoint finder
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, off during reset
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/rrmf_pkg.sv =====
// shared types and constants of the ring run midpoint finder
// no dependencies
package rrmf_pkg;

	localparam int CRD_W = 12;
	localparam int RGB_W = 24;
	localparam logic [RGB_W-1:0] TARGET_RESET = 24'h0070FF;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_LEAD  = 2'd1,
		PH_PAST  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] x;
	} xy_t;

	typedef struct packed {
		logic emit_run;
		logic emit_lead;
		logic last;
		xy_t  run_a;
		xy_t  run_b;
		xy_t  lead_a;
		xy_t  lead_b;
	} entry_t;

endpackage

// ===== rtl/ring_run_midpoint_finder_unit.sv =====
// Takes one ring pixel per cycle when the work queue has room (in_stall is the queue-full flag)
// and, while out_stall is low and the queue holds work, produces one result per cycle from a
// registered output stage; a pixel that closes a run on the ring's last pixel while a lead run
// is pending yields two results from one queue entry, otherwise every result-causing pixel yields
// one. Each result passes through the queue and then the registered output stage, and the
// QUEUE_DEPTH-entry queue absorbs output stalls before the input stalls. target_rgb sits at byte address 0.
// depends on rrmf_pkg, rrmf_front, rrmf_fifo, rrmf_back, assert_macros.svh
`include "assert_macros.svh"

module ring_run_midpoint_finder_unit #(
	parameter int COORD_BITS  = 12,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rrmf_pkg::CRD_W-1:0] pos_x,
	input  logic [rrmf_pkg::CRD_W-1:0] pos_y,
	input  logic [rrmf_pkg::RGB_W-1:0] pixel_rgb,
	input  logic                       ring_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rrmf_pkg::CRD_W-1:0] mid_x,
	output logic [rrmf_pkg::CRD_W-1:0] mid_y,
	output logic                       has_point,
	output logic                       last_of_ring
);
	import rrmf_pkg::*;

	localparam int CB = (COORD_BITS < CRD_W) ? COORD_BITS : CRD_W;

	logic [RGB_W-1:0] target_q;
	logic             q_full, q_push, q_pop, q_valid;
	entry_t           q_wdata, q_head;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? 32'(target_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			target_q <= pwdata[RGB_W-1:0];
		end
	end

	rrmf_front #(.CB(CB)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pixel_rgb  (pixel_rgb),
		.ring_end   (ring_end),
		.target_rgb (target_q),
		.q_full     (q_full),
		.push       (q_push),
		.entry      (q_wdata)
	);

	rrmf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wdata      (q_wdata),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	rrmf_back #(.CB(CB)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (q_valid),
		.head         (q_head),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mid_x        (mid_x),
		.mid_y        (mid_y),
		.has_point    (has_point),
		.last_of_ring (last_of_ring)
	);

	`CHK_IMPL(a_stall_has_work, in_stall, q_valid)
	`CHK_NEXT(a_ring_end_queued, in_valid && !in_stall && ring_end, q_valid)
	`CHK_IMPL(a_empty_only_at_end, out_valid && !has_point, last_of_ring)
	`CHK_IMPL(a_empty_is_zero, out_valid && !has_point, (mid_x == '0) && (mid_y == '0))

endmodule

// ===== rtl/rrmf_front.sv =====
// front end: accepts pixels, tracks runs around the ring, queues work
// depends on rrmf_pkg
module rrmf_front #(
	parameter int CB = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [rrmf_pkg::CRD_W-1:0] pos_x,
	input  logic [rrmf_pkg::CRD_W-1:0] pos_y,
	input  logic [rrmf_pkg::RGB_W-1:0] pixel_rgb,
	input  logic                       ring_end,
	input  logic [rrmf_pkg::RGB_W-1:0] target_rgb,
	input  logic                       q_full,
	output logic                       push,
	output rrmf_pkg::entry_t           entry
);
	import rrmf_pkg::*;

	typedef logic [1:0][CB-1:0] pt_t;

	phase_t phase_q, phase_d;
	logic   run_active_q, run_active_d;
	logic   has_lead_q, has_lead_d;
	pt_t    run_start_q, run_start_d;
	pt_t    lead_end_q, lead_end_d;
	pt_t    first_q, first_d;
	pt_t    cur;
	pt_t    lead_start;
	logic   acc, zone, emit_run, emit_lead;

	assign in_stall = q_full;
	assign acc      = in_valid && !q_full;
	assign zone     = (pixel_rgb == target_rgb);
	assign cur[0]   = pos_x[CB-1:0];
	assign cur[1]   = pos_y[CB-1:0];

	always_comb begin
		phase_d      = phase_q;
		run_active_d = run_active_q;
		has_lead_d   = has_lead_q;
		run_start_d  = run_start_q;
		lead_end_d   = lead_end_q;
		first_d      = first_q;
		emit_run     = 1'b0;
		case (phase_q)
			PH_FIRST: begin
				first_d = cur;
				if (zone) begin
					lead_end_d = cur;
					phase_d    = PH_LEAD;
				end else begin
					phase_d = PH_PAST;
				end
			end
			PH_LEAD: begin
				if (zone) begin
					lead_end_d = cur;
				end else begin
					has_lead_d = 1'b1;
					phase_d    = PH_PAST;
				end
			end
			default: begin
				if (zone) begin
					if (!run_active_q) begin
						run_active_d = 1'b1;
						run_start_d  = cur;
					end
				end else if (run_active_q) begin
					run_active_d = 1'b0;
					emit_run     = 1'b1;
				end
			end
		endcase
		emit_lead  = ring_end && has_lead_d;
		lead_start = run_active_d ? run_start_d : first_d;
	end

	always_comb begin
		entry.emit_run  = emit_run;
		entry.emit_lead = emit_lead;
		entry.last      = ring_end;
		entry.run_a.x   = CRD_W'(run_start_q[0]);
		entry.run_a.y   = CRD_W'(run_start_q[1]);
		entry.run_b.x   = CRD_W'(cur[0]);
		entry.run_b.y   = CRD_W'(cur[1]);
		entry.lead_a.x  = CRD_W'(lead_start[0]);
		entry.lead_a.y  = CRD_W'(lead_start[1]);
		entry.lead_b.x  = CRD_W'(lead_end_d[0]);
		entry.lead_b.y  = CRD_W'(lead_end_d[1]);
	end

	assign push = acc && (emit_run || ring_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			run_active_q <= 1'b0;
			has_lead_q   <= 1'b0;
			run_start_q  <= '0;
			lead_end_q   <= '0;
			first_q      <= '0;
		end else if (acc) begin
			if (ring_end) begin
				phase_q      <= PH_FIRST;
				run_active_q <= 1'b0;
				has_lead_q   <= 1'b0;
				run_start_q  <= '0;
				lead_end_q   <= '0;
				first_q      <= '0;
			end else begin
				phase_q      <= phase_d;
				run_active_q <= run_active_d;
				has_lead_q   <= has_lead_d;
				run_start_q  <= run_start_d;
				lead_end_q   <= lead_end_d;
				first_q      <= first_d;
			end
		end
	end

endmodule

// ===== rtl/rrmf_fifo.sv =====
// short work queue between front and back end
// depends on rrmf_pkg
module rrmf_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rrmf_pkg::entry_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output rrmf_pkg::entry_t head
);
	import rrmf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rrmf_back.sv =====
// back end: expands queued work into results and computes midpoints
// depends on rrmf_pkg
module rrmf_back #(
	parameter int CB = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  rrmf_pkg::entry_t           head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rrmf_pkg::CRD_W-1:0] mid_x,
	output logic [rrmf_pkg::CRD_W-1:0] mid_y,
	output logic                       has_point,
	output logic                       last_of_ring
);
	import rrmf_pkg::*;

	logic              out_valid_q, second_q, second_d;
	logic [CRD_W-1:0]  mid_x_q, mid_y_q;
	logic              has_point_q, last_q;
	logic              load, out_free, pt, lst;
	xy_t               sel_a, sel_b;
	logic [CB:0]       sum_x, sum_y;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		load     = 1'b0;
		pop      = 1'b0;
		second_d = second_q;
		pt       = 1'b0;
		lst      = head.last;
		sel_a    = head.run_a;
		sel_b    = head.run_b;
		if (out_free && head_valid) begin
			load = 1'b1;
			if (second_q) begin
				sel_a    = head.lead_a;
				sel_b    = head.lead_b;
				pt       = 1'b1;
				pop      = 1'b1;
				second_d = 1'b0;
			end else if (head.emit_run && head.emit_lead) begin
				pt       = 1'b1;
				lst      = 1'b0;
				second_d = 1'b1;
			end else if (head.emit_run) begin
				pt  = 1'b1;
				pop = 1'b1;
			end else if (head.emit_lead) begin
				sel_a = head.lead_a;
				sel_b = head.lead_b;
				pt    = 1'b1;
				pop   = 1'b1;
			end else begin
				pop = 1'b1;
			end
		end
	end

	assign sum_x = {1'b0, sel_a.x[CB-1:0]} + {1'b0, sel_b.x[CB-1:0]};
	assign sum_y = {1'b0, sel_a.y[CB-1:0]} + {1'b0, sel_b.y[CB-1:0]};

	always_ff @(posedge clk) begin
		if (load) begin
			mid_x_q     <= pt ? CRD_W'(sum_x[CB:1]) : '0;
			mid_y_q     <= pt ? CRD_W'(sum_y[CB:1]) : '0;
			has_point_q <= pt;
			last_q      <= lst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			second_q <= second_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign mid_x        = mid_x_q;
	assign mid_y        = mid_y_q;
	assign has_point    = has_point_q;
	assign last_of_ring = last_q;

endmodule
